[hw/rtl/wsi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_pkg
// Types and constants shared by the wheel speed integrator modules.
// ----------------------------------------------------------------------------
package wsi_pkg;

   // request fields, all signed Q16.16
   typedef struct packed {
      logic signed [31:0] wheel_speed;
      logic signed [31:0] ground_speed;
      logic signed [31:0] drive_torque;
      logic signed [31:0] service_brake_torque;
      logic signed [31:0] handbrake_torque;
      logic signed [31:0] tire_force;
   } req_type;

   typedef struct packed {
      logic signed [31:0] next_wheel_speed;
      logic               wheel_locked;
   } rsp_type;

   // control flags and wheel speed that ride alongside the divider
   typedef struct packed {
      logic signed [31:0] wheel_speed;
      logic               v_neg;
      logic               n_neg;
      logic               sat;
      logic               brake_on;
      logic               dir_pos;
      logic               dir_neg;
      logic               w_near;
      logic               lock_ok;
      logic               d_pos;
      logic               d_neg;
      logic               force_zero;
      logic               hold;
   } side_type;

   typedef enum logic [1:0] {
      CSR_RADIUS  = 2'd0,
      CSR_INERTIA = 2'd1,
      CSR_TSTEP   = 2'd2
   } csr_index_type;

   localparam int DIV_STEPS  = 54;   // speed increment quotient bits
   localparam int ROLL_STEPS = 48;   // rolling speed quotient bits
   localparam int REM_W      = 31;   // remainder width (divisors are 31 bit)
   localparam int A_W        = 71;   // (|n| * time_step) >> 24
   localparam int LATENCY    = 5 + DIV_STEPS + 4;

   localparam logic [DIV_STEPS-1:0] STEP_CAP = {1'b1, {(DIV_STEPS-1){1'b0}}} >> 0;
   localparam logic signed [31:0]   NEAR_ZERO = 32'sd6;

endpackage

`default_nettype wire

[hw/rtl/wsi_div_pipe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_div_pipe
// Restoring dividers, one quotient bit per stage: speed increment over
// inertia and rolling speed over radius, with sideband carried along.
// ----------------------------------------------------------------------------
module wsi_div_pipe (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [30:0]                           inertia,
   input  wire logic [30:0]                           radius,
   input  wire logic                                  in_valid,
   input  wire logic [wsi_pkg::REM_W-1:0]             in_rem,
   input  wire logic [wsi_pkg::DIV_STEPS-1:0]         in_aq,
   input  wire logic [wsi_pkg::ROLL_STEPS-1:0]        in_vq,
   input  wire wsi_pkg::side_type                     in_side,
   output logic                                       out_valid,
   output logic [wsi_pkg::DIV_STEPS-1:0]              out_q,
   output logic [wsi_pkg::ROLL_STEPS-1:0]             out_roll_q,
   output wsi_pkg::side_type                          out_side
);

   localparam int NS = wsi_pkg::DIV_STEPS;
   localparam int RS = wsi_pkg::ROLL_STEPS;
   localparam int RW = wsi_pkg::REM_W;

   logic              valid_ff [NS];
   logic [RW-1:0]     rem_ff   [NS];
   logic [NS-1:0]     aq_ff    [NS];
   logic [RW-1:0]     rrem_ff  [NS];
   logic [RS-1:0]     vq_ff    [NS];
   wsi_pkg::side_type side_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic              valid_prev;
      logic [RW-1:0]     rem_prev;
      logic [NS-1:0]     aq_prev;
      logic [RW-1:0]     rrem_prev;
      logic [RS-1:0]     vq_prev;
      wsi_pkg::side_type side_prev;
      logic [RW:0]       t_a;
      logic [RW:0]       t_r;
      logic              ge_a;
      logic              ge_r;
      logic [RW-1:0]     rem_in;
      logic [NS-1:0]     aq_in;
      logic [RW-1:0]     rrem_in;
      logic [RS-1:0]     vq_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_rem;
         assign aq_prev    = in_aq;
         assign rrem_prev  = '0;
         assign vq_prev    = in_vq;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign aq_prev    = aq_ff[k-1];
         assign rrem_prev  = rrem_ff[k-1];
         assign vq_prev    = vq_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         t_a    = {rem_prev, aq_prev[NS-1]};
         ge_a   = t_a >= {1'b0, inertia};
         rem_in = ge_a ? RW'(t_a - {1'b0, inertia}) : t_a[RW-1:0];
         aq_in  = {aq_prev[NS-2:0], ge_a};
         t_r    = {rrem_prev, vq_prev[RS-1]};
         ge_r   = t_r >= {1'b0, radius};
         if (k < RS) begin
            rrem_in = ge_r ? RW'(t_r - {1'b0, radius}) : t_r[RW-1:0];
            vq_in   = {vq_prev[RS-2:0], ge_r};
         end else begin
            rrem_in = rrem_prev;
            vq_in   = vq_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k]  <= rem_in;
         aq_ff[k]   <= aq_in;
         rrem_ff[k] <= rrem_in;
         vq_ff[k]   <= vq_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid  = valid_ff[NS-1];
   assign out_q      = aq_ff[NS-1];
   assign out_roll_q = vq_ff[NS-1];
   assign out_side   = side_ff[NS-1];

endmodule

`default_nettype wire

[hw/rtl/wheel_speed_integrator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_speed_integrator
// One explicit Euler step of wheel spin per request, with brake lock,
// rolling speed clamp and undriven speed-up bound. Q16.16 in and out.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is always low. The pipeline depth
// comes from the two bit-per-stage dividers (54 quotient bits for the speed
// step). Reset (synchronous, active high) empties the pipeline and loads the
// default radius, inertia and time step. The receiver cannot stall results.
module wheel_speed_integrator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wsi_pkg::req_type req_data,
   output logic                  rsp_valid,
   output wsi_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   localparam int NS = wsi_pkg::DIV_STEPS;
   localparam int RS = wsi_pkg::ROLL_STEPS;

   // ---------------------------------------------------------------- config
   logic [30:0] radius_ff;
   logic [30:0] inertia_ff;
   logic [31:0] tstep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= 31'd19661;
         inertia_ff <= 31'd65536;
         tstep_ff   <= 32'd139810;
      end else if (csr_write_en) begin
         case (csr_index)
            wsi_pkg::CSR_RADIUS:  radius_ff  <= csr_data[30:0];
            wsi_pkg::CSR_INERTIA: inertia_ff <= csr_data[30:0];
            wsi_pkg::CSR_TSTEP:   tstep_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // never holds off a request
   assign busy = 1'b0;

   function automatic logic near_zero(input logic signed [31:0] x);
      return (x >= -wsi_pkg::NEAR_ZERO) && (x <= wsi_pkg::NEAR_ZERO);
   endfunction

   // ------------------------------------------------- S1: flags, f * radius
   logic               s1_valid_ff;
   wsi_pkg::side_type  s1_side_ff,  s1_side_in;
   logic signed [31:0] s1_v_ff;
   logic signed [31:0] s1_d_ff;
   logic signed [63:0] s1_frad_ff,  s1_frad_in;
   logic [32:0]        s1_brake_ff, s1_brake_in;

   logic signed [31:0] w_i, v_i, d_i, sb_i, hb_i, f_i;
   logic signed [34:0] brake_s;
   logic signed [34:0] d_s;

   always_comb begin
      w_i  = req_data.wheel_speed;
      v_i  = req_data.ground_speed;
      d_i  = req_data.drive_torque;
      sb_i = req_data.service_brake_torque;
      hb_i = req_data.handbrake_torque;
      f_i  = req_data.tire_force;

      // negative brake inputs count as zero
      s1_brake_in = 33'(sb_i > 0 ? sb_i[30:0] : 31'd0)
                  + 33'(hb_i > 0 ? hb_i[30:0] : 31'd0);
      s1_frad_in  = 64'(f_i * $signed({1'b0, radius_ff}));
      brake_s     = $signed({2'b00, s1_brake_in});
      d_s         = 35'(d_i);

      s1_side_in.wheel_speed = w_i;
      s1_side_in.v_neg       = v_i < 0;
      s1_side_in.n_neg       = 1'b0;
      s1_side_in.sat         = 1'b0;
      s1_side_in.brake_on    = s1_brake_in != 33'd0;
      // brake opposes wheel spin, or ground motion when the wheel stands
      s1_side_in.dir_pos     = (w_i > 0) || (w_i == 0 && v_i > 0);
      s1_side_in.dir_neg     = (w_i < 0) || (w_i == 0 && v_i < 0);
      s1_side_in.w_near      = near_zero(w_i);
      s1_side_in.lock_ok     = s1_side_in.dir_pos ? (d_s <= brake_s) : (d_s >= -brake_s);
      s1_side_in.d_pos       = d_i > 0;
      s1_side_in.d_neg       = d_i < 0;
      s1_side_in.force_zero  = (radius_ff == '0) || (inertia_ff == '0) || (tstep_ff == '0);
      // standing wheel held by the brakes
      s1_side_in.hold        = s1_side_in.brake_on && near_zero(w_i) && near_zero(v_i)
                             && near_zero(d_i) && near_zero(f_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_side_ff  <= s1_side_in;
      s1_v_ff     <= v_i;
      s1_d_ff     <= d_i;
      s1_frad_ff  <= s1_frad_in;
      s1_brake_ff <= s1_brake_in;
   end

   // ---------------------------------------------- S2: net torque in Q32.32
   logic               s2_valid_ff;
   wsi_pkg::side_type  s2_side_ff, s2_side_in;
   logic [62:0]        s2_m_ff,    s2_m_in;
   logic [RS-1:0]      s2_vmag_ff, s2_vmag_in;

   logic signed [63:0] net;
   logic signed [63:0] brake_term;
   logic [31:0]        vabs;

   always_comb begin
      brake_term = $signed({15'd0, s1_brake_ff, 16'd0});
      if (s1_side_ff.dir_pos) begin
         net = $signed({{16{s1_d_ff[31]}}, s1_d_ff, 16'd0}) - s1_frad_ff - brake_term;
      end else if (s1_side_ff.dir_neg) begin
         net = $signed({{16{s1_d_ff[31]}}, s1_d_ff, 16'd0}) - s1_frad_ff + brake_term;
      end else begin
         net = $signed({{16{s1_d_ff[31]}}, s1_d_ff, 16'd0}) - s1_frad_ff;
      end
      s2_side_in       = s1_side_ff;
      s2_side_in.n_neg = net < 0;
      s2_m_in          = net < 0 ? 63'(-net) : net[62:0];
      vabs             = s1_v_ff < 0 ? 32'(-s1_v_ff) : s1_v_ff;
      s2_vmag_in       = {vabs, 16'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_side_ff <= s2_side_in;
      s2_m_ff    <= s2_m_in;
      s2_vmag_ff <= s2_vmag_in;
   end

   // -------------------------------------- S3: |net| * time_step, two halves
   logic              s3_valid_ff;
   wsi_pkg::side_type s3_side_ff;
   logic [63:0]       s3_p1_ff;
   logic [62:0]       s3_p2_ff;
   logic [RS-1:0]     s3_vmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_side_ff <= s2_side_ff;
      s3_p1_ff   <= s2_m_ff[31:0] * tstep_ff;
      s3_p2_ff   <= 63'(s2_m_ff[62:32] * tstep_ff);
      s3_vmag_ff <= s2_vmag_ff;
   end

   // ------------------------------------------ S4: product sum, drop Q8.24
   logic                     s4_valid_ff;
   wsi_pkg::side_type        s4_side_ff;
   logic [wsi_pkg::A_W-1:0]  s4_a_ff;
   logic [RS-1:0]            s4_vmag_ff;
   logic [95:0]              prod;

   assign prod = {32'd0, s3_p1_ff} + {1'b0, s3_p2_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_side_ff <= s3_side_ff;
      s4_a_ff    <= prod[94:24];
      s4_vmag_ff <= s3_vmag_ff;
   end

   // ------------------ S5: saturation check, divider start (high part < i)
   logic                           s5_valid_ff;
   wsi_pkg::side_type              s5_side_ff, s5_side_in;
   logic [wsi_pkg::REM_W-1:0]      s5_rem_ff;
   logic [NS-1:0]                  s5_aq_ff;
   logic [RS-1:0]                  s5_vq_ff;

   always_comb begin
      s5_side_in     = s4_side_ff;
      // quotient of 2^54 or more is far past the cap
      s5_side_in.sat = {14'd0, s4_a_ff[wsi_pkg::A_W-1:NS]} >= inertia_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_side_ff <= s5_side_in;
      s5_rem_ff  <= s5_side_in.sat ? '0 : {14'd0, s4_a_ff[wsi_pkg::A_W-1:NS]};
      s5_aq_ff   <= s4_a_ff[NS-1:0];
      s5_vq_ff   <= s4_vmag_ff;
   end

   // ------------------------------------------------------------- dividers
   logic              dv_valid;
   logic [NS-1:0]     dv_q;
   logic [RS-1:0]     dv_roll_q;
   wsi_pkg::side_type dv_side;

   wsi_div_pipe u_div (
      .clock      (clock),
      .reset      (reset),
      .inertia    (inertia_ff),
      .radius     (radius_ff),
      .in_valid   (s5_valid_ff),
      .in_rem     (s5_rem_ff),
      .in_aq      (s5_aq_ff),
      .in_vq      (s5_vq_ff),
      .in_side    (s5_side_ff),
      .out_valid  (dv_valid),
      .out_q      (dv_q),
      .out_roll_q (dv_roll_q),
      .out_side   (dv_side)
   );

   // ------------------------------------- P1: cap step, integrate, roll sign
   logic               p1_valid_ff;
   wsi_pkg::side_type  p1_side_ff;
   logic signed [63:0] p1_next_ff, p1_next_in;
   logic signed [63:0] p1_roll_ff, p1_roll_in;
   logic [NS-1:0]      step_mag;

   always_comb begin
      step_mag   = (dv_side.sat || dv_q > wsi_pkg::STEP_CAP) ? wsi_pkg::STEP_CAP : dv_q;
      p1_next_in = dv_side.n_neg ? 64'(dv_side.wheel_speed) - $signed({10'd0, step_mag})
                                 : 64'(dv_side.wheel_speed) + $signed({10'd0, step_mag});
      p1_roll_in = dv_side.v_neg ? -$signed({16'd0, dv_roll_q}) : $signed({16'd0, dv_roll_q});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= dv_valid;
      end
      p1_side_ff <= dv_side;
      p1_next_ff <= p1_next_in;
      p1_roll_ff <= p1_roll_in;
   end

   // ------------------------------- P2: brake lock / undriven reversal stop
   logic               p2_valid_ff;
   wsi_pkg::side_type  p2_side_ff;
   logic signed [63:0] p2_next_ff, p2_next_in;
   logic signed [63:0] p2_roll_ff;
   logic               p2_lock_ff, p2_lock_in;
   logic               p2_w_le_ff, p2_w_ge_ff;
   logic signed [63:0] w_p1;
   logic               flip;
   logic               stop_undriven;

   always_comb begin
      w_p1 = 64'(p1_side_ff.wheel_speed);
      flip = (w_p1 > 0 && p1_next_ff < 0) || (w_p1 < 0 && p1_next_ff > 0);
      p2_lock_in = p1_side_ff.brake_on && (p1_side_ff.dir_pos || p1_side_ff.dir_neg)
                && p1_side_ff.lock_ok
                && (flip || (p1_side_ff.w_near
                    && (p1_side_ff.dir_pos ? p1_next_ff <= 0 : p1_next_ff >= 0)));
      // drive opposing spin without brakes may stop the wheel, not reverse it
      stop_undriven = !p1_side_ff.brake_on && flip
                   && ((p1_side_ff.d_pos && w_p1 < 0) || (p1_side_ff.d_neg && w_p1 > 0));
      p2_next_in = (p2_lock_in || stop_undriven) ? '0 : p1_next_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_side_ff <= p1_side_ff;
      p2_next_ff <= p2_next_in;
      p2_roll_ff <= p1_roll_ff;
      p2_lock_ff <= p2_lock_in;
      p2_w_le_ff <= w_p1 <= p1_roll_ff;
      p2_w_ge_ff <= w_p1 >= p1_roll_ff;
   end

   // ----------------------------------- P3: clamp overshoot at rolling speed
   logic               p3_valid_ff;
   wsi_pkg::side_type  p3_side_ff;
   logic signed [63:0] p3_next_ff, p3_next_in;
   logic signed [63:0] p3_roll_ff;
   logic               p3_lock_ff;
   logic               p3_w_le_ff;
   logic               n_gt, n_lt, clamp;

   always_comb begin
      n_gt = p2_next_ff > p2_roll_ff;
      n_lt = p2_next_ff < p2_roll_ff;
      if (p2_side_ff.brake_on) begin
         if (p2_side_ff.dir_pos) begin
            clamp = p2_w_le_ff && n_gt;
         end else if (p2_side_ff.dir_neg) begin
            clamp = p2_w_ge_ff && n_lt;
         end else begin
            clamp = 1'b0;
         end
      end else if (p2_side_ff.d_pos) begin
         clamp = p2_w_ge_ff && n_lt;
      end else if (p2_side_ff.d_neg) begin
         clamp = p2_w_le_ff && n_gt;
      end else begin
         // coasting: no crossing of the rolling speed in either direction
         clamp = (!p2_w_le_ff && n_lt) || (!p2_w_ge_ff && n_gt);
      end
      p3_next_in = clamp ? p2_roll_ff : p2_next_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_side_ff <= p2_side_ff;
      p3_next_ff <= p3_next_in;
      p3_roll_ff <= p2_roll_ff;
      p3_lock_ff <= p2_lock_ff;
      p3_w_le_ff <= p2_w_le_ff;
   end

   // ------------------- P4: speed-up bound, saturation, special cases, output
   logic               rsp_valid_ff;
   wsi_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic signed [63:0] w_p3;
   logic signed [63:0] bound;
   logic signed [63:0] next_b;
   logic               roll_pos;
   logic               can_spin;

   always_comb begin
      w_p3     = 64'(p3_side_ff.wheel_speed);
      roll_pos = p3_roll_ff >= 0;
      can_spin = roll_pos ? p3_side_ff.d_pos : p3_side_ff.d_neg;
      if (roll_pos) begin
         bound = p3_w_le_ff ? p3_roll_ff : w_p3;
      end else begin
         bound = (w_p3 < p3_roll_ff) ? w_p3 : p3_roll_ff;
      end
      next_b = p3_next_ff;
      if (!can_spin) begin
         if (roll_pos && p3_next_ff > bound) begin
            next_b = bound;
         end else if (!roll_pos && p3_next_ff < bound) begin
            next_b = bound;
         end
      end

      if (next_b > 64'sd2147483647) begin
         rsp_data_in.next_wheel_speed = 32'sh7FFF_FFFF;
      end else if (next_b < -64'sd2147483648) begin
         rsp_data_in.next_wheel_speed = 32'sh8000_0000;
      end else begin
         rsp_data_in.next_wheel_speed = next_b[31:0];
      end
      rsp_data_in.wheel_locked = p3_lock_ff;

      if (p3_side_ff.force_zero) begin
         rsp_data_in = '0;
      end else if (p3_side_ff.hold) begin
         rsp_data_in.next_wheel_speed = '0;
         rsp_data_in.wheel_locked     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p3_valid_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   a_request_to_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(wsi_pkg::LATENCY) rsp_valid)
      else $error("request produced no result after the pipeline latency");

   a_zero_radius_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && radius_ff == '0 |->
         rsp_data.next_wheel_speed == '0 && !rsp_data.wheel_locked)
      else $error("zero radius must give a zero, unlocked result");

endmodule

`default_nettype wire
